[rtl/tgd_pkg.sv]
// Shared widths, register codes and types of the two-body gravity derivative.
// Pure declarations; depends on nothing else.
package tgd_pkg;

  localparam int NAXIS      = 3;
  localparam int POS_W      = 48;
  localparam int VEL_W      = 40;
  localparam int ACC_W      = 48;
  localparam int MU_W       = 56;
  localparam int CRR_W      = 47;
  localparam int CRS_W      = 39;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 56;

  // Internal widths: squared radius, squared speed, root, R*S, mu*|p|.
  localparam int SQ_W      = 2 * POS_W;
  localparam int VSQ_W     = 2 * VEL_W;
  localparam int ROOT_W    = POS_W;
  localparam int RT_REM_W  = ROOT_W + 4;
  localparam int DEN_W     = ROOT_W + SQ_W;
  localparam int PM_W      = POS_W + MU_W;
  localparam int RS_W      = SQ_W + ROOT_W / 2;
  localparam int Q_W       = ACC_W;
  localparam int NUM_SHIFT = 16;

  localparam int POS_HALF = POS_W / 2;
  localparam int VEL_HALF = VEL_W / 2;
  localparam int MU_HALF  = MU_W / 2;
  localparam int PP_W     = 2 * POS_HALF;
  localparam int VPP_W    = 2 * VEL_HALF;
  localparam int MPP_W    = POS_HALF + MU_HALF;

  localparam logic [MU_W-1:0]  MU_RESET = 56'd102041600;
  localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRASH_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRASH_SPEED  = 2'd2;

  // Per-item side information that rides along the whole pipeline.
  typedef struct packed {
    logic [NAXIS-1:0][VEL_W-1:0] vel;
    logic [NAXIS-1:0]            pneg;
    logic                        crash;
    logic                        zero;
  } side_t;

endpackage

[rtl/two_body_gravity_derivative.sv]
// One beat per cycle unless stalled; 48 square-root stages and 48 divider stages,
// one bit each, set the depth. The whole pipeline advances whenever the output
// register is empty or being taken; an empty first stage also fills while stalled.
// Reset (rst_n, synchronous): clears all valid bits; mu returns to Earth, limits to 0.
// Uses tgd_pkg.
module two_body_gravity_derivative (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tgd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tgd_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [tgd_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [tgd_pkg::POS_W-1:0]  in_pos_z,
  input  logic signed [tgd_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [tgd_pkg::VEL_W-1:0]  in_vel_y,
  input  logic signed [tgd_pkg::VEL_W-1:0]  in_vel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tgd_pkg::VEL_W-1:0]  out_rate_x,
  output logic signed [tgd_pkg::VEL_W-1:0]  out_rate_y,
  output logic signed [tgd_pkg::VEL_W-1:0]  out_rate_z,
  output logic signed [tgd_pkg::ACC_W-1:0]  out_accel_x,
  output logic signed [tgd_pkg::ACC_W-1:0]  out_accel_y,
  output logic signed [tgd_pkg::ACC_W-1:0]  out_accel_z,
  output logic                              out_crashed,
  output logic                              out_saturated,
  output logic                              out_zero_radius
);
  import tgd_pkg::*;

  // Configuration registers.
  logic [MU_W-1:0]  mu_r;
  logic [CRR_W-1:0] crr_r;
  logic [CRS_W-1:0] crs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r  <= MU_RESET;
      crr_r <= '0;
      crs_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRAVITY:      mu_r  <= cfg_data[MU_W-1:0];
        CFG_CRASH_RADIUS: crr_r <= cfg_data[CRR_W-1:0];
        CFG_CRASH_SPEED:  crs_r <= cfg_data[CRS_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control.
  logic adv, ld1;
  logic out_valid_r;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, m1_v_r, m2_v_r, m3_v_r;

  assign adv      = !out_valid_r || out_ready;
  assign ld1      = adv || !s1_v_r;
  assign in_ready = ld1;

  // Stage 1: magnitudes and signs.
  logic [NAXIS-1:0][POS_W-1:0] pin, pmag_nxt;
  logic [NAXIS-1:0][VEL_W-1:0] vin, vmag_nxt;
  logic [NAXIS-1:0]            pneg_nxt;
  logic [NAXIS-1:0][POS_W-1:0] s1_pmag_r;
  logic [NAXIS-1:0][VEL_W-1:0] s1_vmag_r;
  side_t                       s1_side_r;

  assign pin = {in_pos_z, in_pos_y, in_pos_x};
  assign vin = {in_vel_z, in_vel_y, in_vel_x};

  always_comb begin
    for (int c = 0; c < NAXIS; c++) begin
      pneg_nxt[c] = pin[c][POS_W-1];
      pmag_nxt[c] = pin[c][POS_W-1] ? (POS_W'(0) - pin[c]) : pin[c];
      vmag_nxt[c] = vin[c][VEL_W-1] ? (VEL_W'(0) - vin[c]) : vin[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ld1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      s1_pmag_r       <= pmag_nxt;
      s1_vmag_r       <= vmag_nxt;
      s1_side_r.vel   <= vin;
      s1_side_r.pneg  <= pneg_nxt;
      s1_side_r.crash <= 1'b0;
      s1_side_r.zero  <= 1'b0;
    end
  end

  // Stage 2: half-width partial products of every square.
  logic [NAXIS-1:0][PP_W-1:0]  s2_phh_r, s2_phl_r, s2_pll_r;
  logic [NAXIS-1:0][VPP_W-1:0] s2_vhh_r, s2_vhl_r, s2_vll_r;
  logic [PP_W-1:0]             s2_chh_r, s2_chl_r, s2_cll_r;
  logic [VPP_W-1:0]            s2_shh_r, s2_shl_r, s2_sll_r;
  logic [NAXIS-1:0][POS_W-1:0] s2_pmag_r;
  side_t                       s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NAXIS; c++) begin
        s2_phh_r[c] <= s1_pmag_r[c][POS_W-1:POS_HALF] * s1_pmag_r[c][POS_W-1:POS_HALF];
        s2_phl_r[c] <= s1_pmag_r[c][POS_W-1:POS_HALF] * s1_pmag_r[c][POS_HALF-1:0];
        s2_pll_r[c] <= s1_pmag_r[c][POS_HALF-1:0] * s1_pmag_r[c][POS_HALF-1:0];
        s2_vhh_r[c] <= s1_vmag_r[c][VEL_W-1:VEL_HALF] * s1_vmag_r[c][VEL_W-1:VEL_HALF];
        s2_vhl_r[c] <= s1_vmag_r[c][VEL_W-1:VEL_HALF] * s1_vmag_r[c][VEL_HALF-1:0];
        s2_vll_r[c] <= s1_vmag_r[c][VEL_HALF-1:0] * s1_vmag_r[c][VEL_HALF-1:0];
      end
      s2_chh_r  <= crr_r[CRR_W-1:POS_HALF] * crr_r[CRR_W-1:POS_HALF];
      s2_chl_r  <= crr_r[CRR_W-1:POS_HALF] * crr_r[POS_HALF-1:0];
      s2_cll_r  <= crr_r[POS_HALF-1:0] * crr_r[POS_HALF-1:0];
      s2_shh_r  <= crs_r[CRS_W-1:VEL_HALF] * crs_r[CRS_W-1:VEL_HALF];
      s2_shl_r  <= crs_r[CRS_W-1:VEL_HALF] * crs_r[VEL_HALF-1:0];
      s2_sll_r  <= crs_r[VEL_HALF-1:0] * crs_r[VEL_HALF-1:0];
      s2_pmag_r <= s1_pmag_r;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: assemble the squares. The cross term counts twice.
  logic [NAXIS-1:0][SQ_W-1:0]  s3_psq_r;
  logic [NAXIS-1:0][VSQ_W-1:0] s3_vsq_r;
  logic [SQ_W-1:0]             s3_crsq_r;
  logic [VSQ_W-1:0]            s3_cssq_r;
  logic [NAXIS-1:0][POS_W-1:0] s3_pmag_r;
  side_t                       s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NAXIS; c++) begin
        s3_psq_r[c] <= (SQ_W'(s2_phh_r[c]) << PP_W) + (SQ_W'(s2_phl_r[c]) << (POS_HALF + 1))
                       + SQ_W'(s2_pll_r[c]);
        s3_vsq_r[c] <= (VSQ_W'(s2_vhh_r[c]) << VPP_W)
                       + (VSQ_W'(s2_vhl_r[c]) << (VEL_HALF + 1)) + VSQ_W'(s2_vll_r[c]);
      end
      s3_crsq_r <= (SQ_W'(s2_chh_r) << PP_W) + (SQ_W'(s2_chl_r) << (POS_HALF + 1))
                   + SQ_W'(s2_cll_r);
      s3_cssq_r <= (VSQ_W'(s2_shh_r) << VPP_W) + (VSQ_W'(s2_shl_r) << (VEL_HALF + 1))
                   + VSQ_W'(s2_sll_r);
      s3_pmag_r <= s2_pmag_r;
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: sums of squares.
  logic [SQ_W-1:0]             s4_s_r, s4_crsq_r;
  logic [VSQ_W-1:0]            s4_sv_r, s4_cssq_r;
  logic [NAXIS-1:0][POS_W-1:0] s4_pmag_r;
  side_t                       s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s_r    <= s3_psq_r[0] + s3_psq_r[1] + s3_psq_r[2];
      s4_sv_r   <= s3_vsq_r[0] + s3_vsq_r[1] + s3_vsq_r[2];
      s4_crsq_r <= s3_crsq_r;
      s4_cssq_r <= s3_cssq_r;
      s4_pmag_r <= s3_pmag_r;
      s4_side_r <= s3_side_r;
    end
  end

  // Square root, one result bit per stage. Entry 0 also takes the crash and
  // zero-radius decisions.
  logic                        sq_v_r    [0:ROOT_W];
  logic [SQ_W-1:0]             sq_s_r    [0:ROOT_W];
  logic [RT_REM_W-1:0]         sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]           sq_root_r [0:ROOT_W];
  logic [NAXIS-1:0][POS_W-1:0] sq_pmag_r [0:ROOT_W];
  side_t                       sq_side_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_s_r[0]          <= s4_s_r;
      sq_rem_r[0]        <= '0;
      sq_root_r[0]       <= '0;
      sq_pmag_r[0]       <= s4_pmag_r;
      sq_side_r[0].vel   <= s4_side_r.vel;
      sq_side_r[0].pneg  <= s4_side_r.pneg;
      sq_side_r[0].crash <= (s4_s_r <= s4_crsq_r) || (s4_sv_r <= s4_cssq_r);
      sq_side_r[0].zero  <= (s4_s_r == '0);
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [RT_REM_W-1:0] rsh, trial, rdif;
    logic                ge;

    always_comb begin
      rsh   = {sq_rem_r[k][RT_REM_W-3:0], sq_s_r[k][2*B+1 -: 2]};
      trial = {2'b00, sq_root_r[k], 2'b01};
      ge    = (rsh >= trial);
      rdif  = rsh - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k+1]  <= ge ? rdif : rsh;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_s_r[k+1]    <= sq_s_r[k];
        sq_pmag_r[k+1] <= sq_pmag_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  end

  // Multiplier stage 1: partial products of R*S and of |p|*mu.
  logic [1:0][3:0][PP_W-1:0]        m1_rs_r;
  logic [NAXIS-1:0][1:0][1:0][MPP_W-1:0] m1_pm_r;
  side_t                            m1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= sq_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int h = 0; h < 2; h++) begin
        for (int j = 0; j < 4; j++) begin
          m1_rs_r[h][j] <= sq_root_r[ROOT_W][POS_HALF*h +: POS_HALF]
                           * sq_s_r[ROOT_W][POS_HALF*j +: POS_HALF];
        end
      end
      for (int c = 0; c < NAXIS; c++) begin
        for (int h = 0; h < 2; h++) begin
          for (int g = 0; g < 2; g++) begin
            m1_pm_r[c][h][g] <= sq_pmag_r[ROOT_W][c][POS_HALF*h +: POS_HALF]
                                * mu_r[MU_HALF*g +: MU_HALF];
          end
        end
      end
      m1_side_r <= sq_side_r[ROOT_W];
    end
  end

  // Multiplier stage 2: partial sums.
  logic [1:0][RS_W-1:0]        m2_rs_r;
  logic [NAXIS-1:0][PM_W-1:0]  m2_pm_r;
  side_t                       m2_side_r;
  logic [1:0][RS_W-1:0]        rs_sum;
  logic [NAXIS-1:0][PM_W-1:0]  pm_sum;

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      rs_sum[h] = '0;
      for (int j = 0; j < 4; j++) begin
        rs_sum[h] = rs_sum[h] + (RS_W'(m1_rs_r[h][j]) << (POS_HALF * j));
      end
    end
    for (int c = 0; c < NAXIS; c++) begin
      pm_sum[c] = '0;
      for (int h = 0; h < 2; h++) begin
        for (int g = 0; g < 2; g++) begin
          pm_sum[c] = pm_sum[c] + (PM_W'(m1_pm_r[c][h][g]) << (POS_HALF * h + MU_HALF * g));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_rs_r   <= rs_sum;
      m2_pm_r   <= pm_sum;
      m2_side_r <= m1_side_r;
    end
  end

  // Multiplier stage 3: final R*S.
  logic [DEN_W-1:0]            m3_den_r;
  logic [NAXIS-1:0][PM_W-1:0]  m3_pm_r;
  side_t                       m3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (adv) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_den_r  <= DEN_W'(m2_rs_r[0]) + (DEN_W'(m2_rs_r[1]) << POS_HALF);
      m3_pm_r   <= m2_pm_r;
      m3_side_r <= m2_side_r;
    end
  end

  // Divider. The dividend is mu*|p|*2^64; its low 48 bits are zero, so the
  // partial remainder starts at mu*|p|*2^16 and zeros shift in. Entry 0 flags
  // a quotient of 2^48 or more, which saturates unless the radius is zero.
  logic                        dv_v_r   [0:Q_W];
  logic [DEN_W-1:0]            dv_den_r [0:Q_W];
  logic [NAXIS-1:0][DEN_W-1:0] dv_rem_r [0:Q_W];
  logic [NAXIS-1:0][Q_W-1:0]   dv_q_r   [0:Q_W];
  logic [NAXIS-1:0]            dv_ov_r  [0:Q_W];
  side_t                       dv_side_r[0:Q_W];
  logic [NAXIS-1:0][DEN_W-1:0] rem0;

  always_comb begin
    for (int c = 0; c < NAXIS; c++) begin
      rem0[c] = DEN_W'({m3_pm_r[c], {NUM_SHIFT{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NAXIS; c++) begin
        dv_ov_r[0][c] <= (rem0[c] >= m3_den_r);
      end
      dv_rem_r[0]  <= rem0;
      dv_q_r[0]    <= '0;
      dv_den_r[0]  <= m3_den_r;
      dv_side_r[0] <= m3_side_r;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [NAXIS-1:0][DEN_W:0]   rsh, rdif;
    logic [NAXIS-1:0]            ge;

    always_comb begin
      for (int c = 0; c < NAXIS; c++) begin
        rsh[c]  = {dv_rem_r[k][c], 1'b0};
        ge[c]   = (rsh[c] >= {1'b0, dv_den_r[k]});
        rdif[c] = rsh[c] - {1'b0, dv_den_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < NAXIS; c++) begin
          dv_rem_r[k+1][c] <= ge[c] ? rdif[c][DEN_W-1:0] : rsh[c][DEN_W-1:0];
          dv_q_r[k+1][c]   <= {dv_q_r[k][c][Q_W-2:0], ge[c]};
        end
        dv_ov_r[k+1]   <= dv_ov_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // Output register: sign, saturation and the zero-radius override.
  logic [NAXIS-1:0][ACC_W-1:0] acc_nxt;
  logic [NAXIS-1:0]            sat_c;
  logic [NAXIS-1:0][ACC_W-1:0] out_acc_r;
  logic [NAXIS-1:0][VEL_W-1:0] out_rate_r;
  logic                        out_crash_r, out_sat_r, out_zero_r;
  side_t                       fin_side;
  logic [NAXIS-1:0][Q_W-1:0]   fin_q;

  assign fin_side = dv_side_r[Q_W];
  assign fin_q    = dv_q_r[Q_W];

  always_comb begin
    for (int c = 0; c < NAXIS; c++) begin
      // A positive result may reach 2^47-1, a negative one -2^47.
      sat_c[c] = dv_ov_r[Q_W][c] || (fin_side.pneg[c] ? fin_q[c][Q_W-1]
                 : (fin_q[c][Q_W-1] && |fin_q[c][Q_W-2:0]));
      if (fin_side.zero) begin
        acc_nxt[c] = '0;
      end else if (sat_c[c]) begin
        acc_nxt[c] = fin_side.pneg[c] ? ACC_MAX : ACC_MIN;
      end else begin
        acc_nxt[c] = fin_side.pneg[c] ? fin_q[c] : (ACC_W'(0) - fin_q[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_acc_r   <= acc_nxt;
      out_rate_r  <= fin_side.vel;
      out_crash_r <= fin_side.crash;
      out_sat_r   <= !fin_side.zero && (|sat_c);
      out_zero_r  <= fin_side.zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_x      = out_rate_r[0];
  assign out_rate_y      = out_rate_r[1];
  assign out_rate_z      = out_rate_r[2];
  assign out_accel_x     = out_acc_r[0];
  assign out_accel_y     = out_acc_r[1];
  assign out_accel_z     = out_acc_r[2];
  assign out_crashed     = out_crash_r;
  assign out_saturated   = out_sat_r;
  assign out_zero_radius = out_zero_r;

  // A zero radius always reports a crash and zero acceleration, never saturation.
  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_radius |->
      out_crashed && !out_saturated && out_accel_x == '0 && out_accel_y == '0
      && out_accel_z == '0)
    else $error("zero radius result is inconsistent");

  // Input back-pressure only comes from a held result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  // While the pipeline is frozen the last divider stage keeps its beat.
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_v_r[Q_W]) && (!dv_v_r[Q_W] || $stable(dv_q_r[Q_W])))
    else $error("divider output moved during a stall");

  // A frozen output register keeps its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accel_x) && $stable(out_rate_x))
    else $error("held result changed");

endmodule

[dv/tb_two_body_gravity_derivative.sv]
// Self-checking testbench for two_body_gravity_derivative: a directed table and
// random state vectors, predicted with exact wide integer arithmetic.
// Depends on tgd_pkg and the top-level RTL only.
module tb_two_body_gravity_derivative;
  timeunit 1ns;
  timeprecision 1ps;
  import tgd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 500;

  typedef struct packed {
    logic [NAXIS-1:0][POS_W-1:0] pos;
    logic [NAXIS-1:0][VEL_W-1:0] vel;
  } orbit_state_t;

  typedef struct packed {
    logic [NAXIS-1:0][VEL_W-1:0] rate;
    logic [NAXIS-1:0][ACC_W-1:0] accel;
    logic                        crashed;
    logic                        saturated;
    logic                        zero_radius;
  } deriv_t;

  typedef struct {
    orbit_state_t st;
    bit           known;
    deriv_t       want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [VEL_W-1:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEL_W-1:0] out_rate_x, out_rate_y, out_rate_z;
  logic signed [ACC_W-1:0] out_accel_x, out_accel_y, out_accel_z;
  logic out_crashed, out_saturated, out_zero_radius;

  two_body_gravity_derivative uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [MU_W-1:0]  mu_reg;
  logic [CRR_W-1:0] crash_radius_reg;
  logic [CRS_W-1:0] crash_speed_reg;

  deriv_t pending_derivs[$];
  table_row_t dir_rows[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit in_reset = 1'b1;

  function automatic deriv_t predict_deriv(orbit_state_t st);
    logic [255:0] sq, vsq, lim, den, num, quo, t2;
    logic [NAXIS-1:0][POS_W-1:0] pm;
    logic [NAXIS-1:0] pneg;
    logic [POS_W-1:0] root, cand;
    logic [VEL_W-1:0] vm;
    deriv_t d;
    sq = '0;
    vsq = '0;
    for (int i = 0; i < NAXIS; i++) begin
      pneg[i] = st.pos[i][POS_W-1];
      pm[i] = pneg[i] ? -st.pos[i] : st.pos[i];
      vm = st.vel[i][VEL_W-1] ? -st.vel[i] : st.vel[i];
      t2 = 256'(pm[i]);
      sq = sq + t2 * t2;
      t2 = 256'(vm);
      vsq = vsq + t2 * t2;
      d.rate[i] = st.vel[i];
    end
    lim = 256'(crash_radius_reg);
    d.crashed = sq <= lim * lim;
    lim = 256'(crash_speed_reg);
    if (vsq <= lim * lim) d.crashed = 1'b1;
    d.zero_radius = (sq == 0);
    d.saturated = 1'b0;
    d.accel = '0;
    if (!d.zero_radius) begin
      root = '0;
      for (int b = POS_W - 1; b >= 0; b--) begin
        cand = root | (48'd1 << b);
        t2 = 256'(cand);
        if (t2 * t2 <= sq) root = cand;
      end
      den = 256'(root) * sq;
      for (int i = 0; i < NAXIS; i++) begin
        num = (256'(mu_reg) * 256'(pm[i])) << 64;
        quo = num / den;
        lim = pneg[i] ? 256'(ACC_MAX) : 256'(ACC_MAX) + 256'd1;
        if (quo > lim) begin
          d.saturated = 1'b1;
          d.accel[i] = pneg[i] ? ACC_MAX : ACC_MIN;
        end else begin
          d.accel[i] = pneg[i] ? quo[ACC_W-1:0] : -quo[ACC_W-1:0];
        end
      end
    end
    return d;
  endfunction

  // Mostly orbit-sized values with random content; the rest hits the edges.
  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1:    return r[POS_W-1:0];
      2:       return 48'(signed'(32'($urandom_range(255)) - 32'sd128));
      3:       return '0;
      default: return 48'(signed'(r[33:0]));
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] rand_vel();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1:    return r[VEL_W-1:0];
      2:       return '0;
      default: return 40'(signed'(r[24:0]));
    endcase
  endfunction

  function automatic orbit_state_t rand_state();
    orbit_state_t st;
    for (int i = 0; i < NAXIS; i++) begin
      st.pos[i] = rand_pos();
      st.vel[i] = rand_vel();
    end
    return st;
  endfunction

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GRAVITY:      mu_reg = val[MU_W-1:0];
      CFG_CRASH_RADIUS: crash_radius_reg = val[CRR_W-1:0];
      CFG_CRASH_SPEED:  crash_speed_reg = val[CRS_W-1:0];
      default: ;
    endcase
  endtask

  // Called from the clock-synchronous flow; returns once the DUT has accepted the state.
  task automatic send_state(orbit_state_t st, bit known, deriv_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_pos_x, in_pos_y, in_pos_z} <= {st.pos[0], st.pos[1], st.pos[2]};
    {in_vel_x, in_vel_y, in_vel_z} <= {st.vel[0], st.vel[1], st.vel[2]};
    do @(posedge clk); while (!in_ready);
    pending_derivs.push_back(known ? want : predict_deriv(st));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_row(orbit_state_t st, bit known, deriv_t want);
    table_row_t row;
    row.st = st;
    row.known = known;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_table();
    orbit_state_t st;
    deriv_t w;
    st = '0;
    st.vel = {40'sd5, -40'sd3, 40'sd7};
    w = '0;
    w.rate = st.vel;
    w.crashed = 1'b1;
    w.zero_radius = 1'b1;
    add_row(st, 1'b1, w);
    st.pos[0] = 48'd1;
    w = '0;
    w.rate = st.vel;
    w.accel[0] = ACC_MIN;
    w.saturated = 1'b1;
    add_row(st, 1'b1, w);
    st.pos[0] = -48'sd1;
    w.accel[0] = ACC_MAX;
    add_row(st, 1'b1, w);
    st.pos = {3{ACC_MAX}};
    st.vel = {3{40'h7F_FFFF_FFFF}};
    add_row(st, 1'b0, w);
    st.pos = {3{ACC_MIN}};
    st.vel = {3{40'h80_0000_0000}};
    add_row(st, 1'b0, w);
    st.pos = {48'sd458752000, 48'sd0, 48'sd0};
    st.vel = '0;
    add_row(st, 1'b0, w);
    st.pos = {-48'sd300000000, 48'sd200000000, -48'sd100000000};
    st.vel = {40'sd7000000, -40'sd1000000, 40'sd1};
    add_row(st, 1'b0, w);
    st.pos = {48'sd0, 48'sd0, ACC_MIN};
    add_row(st, 1'b0, w);
    st.pos = {48'sd0, -48'sd1, 48'sd0};
    add_row(st, 1'b0, w);
    for (int i = 0; i < 6; i++) add_row(rand_state(), 1'b0, w);
  endfunction

  // Receiver side; a long hold-off fills the pipeline and stalls the input.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    deriv_t got, want;
    if (out_valid && out_ready) begin
      // Entry 0 of each axis array is x.
      got.rate = {out_rate_z, out_rate_y, out_rate_x};
      got.accel = {out_accel_z, out_accel_y, out_accel_x};
      got.crashed = out_crashed;
      got.saturated = out_saturated;
      got.zero_radius = out_zero_radius;
      if (pending_derivs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_derivs.pop_front();
        if (got.rate !== want.rate || got.accel !== want.accel ||
            got.crashed !== want.crashed || got.saturated !== want.saturated ||
            got.zero_radius !== want.zero_radius) begin
          mismatches++;
          if (mismatches <= 10) begin
            for (int i = 0; i < NAXIS; i++)
              $display("axis %0d rate exp %h act %h accel exp %h act %h", i,
                       want.rate[i], got.rate[i], want.accel[i], got.accel[i]);
            $display("flags crash/sat/zero exp %b%b%b act %b%b%b",
                     want.crashed, want.saturated, want.zero_radius,
                     got.crashed, got.saturated, got.zero_radius);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (in_reset || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[two_body_gravity_derivative] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    deriv_t none;
    none = '0;
    mu_reg = MU_RESET;
    crash_radius_reg = '0;
    crash_speed_reg = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_reset = 1'b0;
    build_table();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 19;
          write_cfg(CFG_GRAVITY, {MU_W{1'b1}});
          write_cfg(CFG_CRASH_RADIUS, 56'(30'($urandom)));
          write_cfg(CFG_CRASH_SPEED, 56'(22'($urandom)));
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_cfg(CFG_GRAVITY, '0);
          write_cfg(CFG_CRASH_RADIUS, {CFG_DATA_W{1'b1}});
          write_cfg(CFG_CRASH_SPEED, {CFG_DATA_W{1'b1}});
        end
        default: begin
          write_cfg(CFG_GRAVITY, 56'({$urandom, $urandom}) >> $urandom_range(40, 4));
          write_cfg(CFG_CRASH_RADIUS, 56'($urandom_range(1000)));
          write_cfg(CFG_CRASH_SPEED, 56'($urandom_range(1000)));
          // The spare index must leave every register alone.
          write_cfg(CFG_SPARE, {CFG_DATA_W{1'b1}});
        end
      endcase
      cfg_wr_en <= 1'b0;
      if (phase == 0)
        foreach (dir_rows[r]) send_state(dir_rows[r].st, dir_rows[r].known, dir_rows[r].want);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        send_state(rand_state(), 1'b0, none);
      end
      drain();
    end
    if (mismatches == 0 && pending_derivs.size() == 0) begin
      $display("[two_body_gravity_derivative] OK");
    end else begin
      $display("[two_body_gravity_derivative] ERROR");
    end
    $finish;
  end

endmodule
